@@ rtl/shr_pkg.sv @@
// Shared types, constants and helpers for the selection highlight rectangle block.
package shr_pkg;

  // Coordinates are signed and wide enough for row deltas times the line height.
  localparam int CW     = 28;
  localparam int OUTW   = 32;
  localparam int NRECT  = 3;
  localparam int NW     = 2;
  localparam int CIDXW  = 3;
  localparam int CDATAW = 15;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [CIDXW-1:0] {
    CFG_VIEW_LEFT   = 3'd0,
    CFG_VIEW_WIDTH  = 3'd1,
    CFG_VIEW_HEIGHT = 3'd2,
    CFG_CONTENT_TOP = 3'd3,
    CFG_CHAR_WIDTH  = 3'd4,
    CFG_LINE_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] view_left;
    logic [14:0] view_width;
    logic [14:0] view_height;
    logic [14:0] content_top;
    logic [7:0]  char_width;
    logic [7:0]  line_height;
  } cfg_t;

  typedef struct packed {
    logic [14:0] start_col_px;
    logic [15:0] start_row;
    logic [14:0] end_col_px;
    logic [15:0] end_row;
    logic [14:0] scroll_x;
    logic [15:0] scroll_row;
  } item_t;

  typedef struct packed {
    coord_t lx;
    coord_t ly;
    coord_t x;
    coord_t y;
    coord_t right;
    coord_t bottom;
  } geom_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  typedef struct packed {
    rect_t [NRECT-1:0] rects;
    logic  [NW-1:0]    n;
  } rect_set_t;

  function automatic coord_t smin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t smax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic rect_t mk_rect(input coord_t l, input coord_t t,
                                    input coord_t r, input coord_t b);
    rect_t rc;
    rc.left   = l;
    rc.top    = t;
    rc.right  = r;
    rc.bottom = b;
    return rc;
  endfunction

endpackage

@@ rtl/shr_geom.sv @@
// First stage: maps selection endpoints into view coordinates and registers them.
module shr_geom (
  input  logic           clk_i,
  input  logic           en_i,
  input  shr_pkg::item_t item_i,
  input  shr_pkg::cfg_t  cfg_i,
  output shr_pkg::geom_t geom_o
);
  import shr_pkg::*;

  logic signed [16:0] drow_s;
  logic signed [16:0] drow_e;
  logic signed [8:0]  vu_s;
  logic signed [25:0] prod_s;
  logic signed [25:0] prod_e;
  coord_t             prod_s_x;
  coord_t             prod_e_x;
  coord_t             vl;
  coord_t             ct;
  coord_t             sx;
  geom_t              geom_d;
  geom_t              geom_q;

  always_comb begin
    vl     = coord_t'(cfg_i.view_left);
    ct     = coord_t'(cfg_i.content_top);
    sx     = coord_t'(item_i.scroll_x);
    vu_s   = $signed({1'b0, cfg_i.line_height});
    drow_s = $signed({1'b0, item_i.start_row}) - $signed({1'b0, item_i.scroll_row});
    drow_e = $signed({1'b0, item_i.end_row}) - $signed({1'b0, item_i.scroll_row});
    prod_s = 26'(drow_s) * 26'(vu_s);
    prod_e = 26'(drow_e) * 26'(vu_s);
    prod_s_x = coord_t'(prod_s);
    prod_e_x = coord_t'(prod_e);

    geom_d.lx     = vl + coord_t'(item_i.start_col_px) - sx;
    geom_d.x      = vl + coord_t'(item_i.end_col_px) - sx;
    geom_d.ly     = ct + prod_s_x;
    geom_d.y      = ct + prod_e_x;
    geom_d.right  = vl + coord_t'(cfg_i.view_width) - coord_t'(1);
    geom_d.bottom = ct + coord_t'(cfg_i.view_height) - coord_t'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

@@ rtl/shr_rects.sv @@
// Second stage logic: builds the ordered list of clipped highlight rectangles.
module shr_rects (
  input  shr_pkg::geom_t     geom_i,
  input  shr_pkg::cfg_t      cfg_i,
  output shr_pkg::rect_set_t set_o
);
  import shr_pkg::*;

  coord_t lx, ly, x, y, right, bottom;
  coord_t vl, ct, hu, vu, one;
  coord_t h, ty, by, tx, bx, ty2, by2, bxa;
  rect_set_t set;
  logic [NW-1:0] idx;

  always_comb begin
    lx     = geom_i.lx;
    ly     = geom_i.ly;
    x      = geom_i.x;
    y      = geom_i.y;
    right  = geom_i.right;
    bottom = geom_i.bottom;
    vl     = coord_t'(cfg_i.view_left);
    ct     = coord_t'(cfg_i.content_top);
    hu     = coord_t'(cfg_i.char_width);
    vu     = coord_t'(cfg_i.line_height);
    one    = coord_t'(1);

    h   = (y > ly) ? (y - ly) : (ly - y);
    ty  = smin(ly, y);
    by  = smax(ly, y);
    tx  = (x <= lx) ? x : lx;
    bx  = (x <= lx) ? (lx + hu - one) : (x - one);
    ty2 = smax(ty, ct - vu);
    by2 = smin(by, bottom);
    bxa = smin(lx + hu - one, right);

    set.rects = '0;
    idx       = '0;

    if (h <= one) begin
      set.rects[idx] = mk_rect(smax(tx, vl), y, smin(bx, right), y + vu - one);
      idx = idx + 1'b1;
    end else if (by >= ct && ty <= bottom) begin
      // The middle band spans the full view width between the end lines.
      if (h > vu) begin
        set.rects[idx] = mk_rect(vl, ty2 + vu, right, by2 - one);
        idx = idx + 1'b1;
      end
      if (y < ly) begin
        if (y >= ct) begin
          set.rects[idx] = mk_rect(smax(x, vl), y, right, y + vu - one);
          idx = idx + 1'b1;
        end
        set.rects[idx] = mk_rect(vl, ly, bxa, ly + vu - one);
        idx = idx + 1'b1;
      end else begin
        set.rects[idx] = mk_rect(smax(lx, vl), ly, right, ly + vu - one);
        idx = idx + 1'b1;
        if (y + vu - one < bottom) begin
          set.rects[idx] = mk_rect(vl, y, smin(x - one, right), y + vu - one);
          idx = idx + 1'b1;
        end
      end
    end
    set.n = idx;
  end

  assign set_o = set;

endmodule

@@ rtl/shr_outq.sv @@
// Result buffer: holds up to three rectangles and presents one per cycle.
module shr_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  shr_pkg::rect_set_t set_i,
  output logic               free_o,
  output logic               valid_o,
  output shr_pkg::rect_t     rect_o,
  output logic               last_o
);
  import shr_pkg::*;

  rect_t [NRECT-1:0] buf_q;
  rect_t [NRECT-1:0] buf_d;
  logic  [NW-1:0]    cnt_q;
  logic  [NW-1:0]    cnt_d;

  // The head entry is presented every cycle the buffer is not empty, so it
  // leaves at the next edge; a new set may load while the final entry leaves.
  always_comb begin
    free_o = (cnt_q <= NW'(1));
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      buf_d = set_i.rects;
      cnt_d = set_i.n;
    end else if (cnt_q != '0) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign valid_o = (cnt_q != '0);
  assign rect_o  = buf_q[0];
  assign last_o  = (cnt_q == NW'(1));

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(NRECT))
    else $error("result buffer count out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> cnt_q <= NW'(1))
    else $error("result buffer loaded while earlier results still pending");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q == $past(set_i.n))
    else $error("result buffer count does not match loaded set");

endmodule

@@ rtl/selection_highlight_rects.sv @@
// Top level: configuration registers, input register and stage control.
// A selection passes the input register, geometry register and rectangle buffer.
// A selection yields up to three rectangles; later ones can enter as they drain.
// The rectangle buffer reloads in the cycle its final entry goes out.
// Results cannot be stalled; busy rises only while the buffer is draining.
// Reset clears all valid flags; char width and line height become 8, the rest 0.
module selection_highlight_rects (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [14:0]                 start_col_px_i,
  input  logic [15:0]                 start_row_i,
  input  logic [14:0]                 end_col_px_i,
  input  logic [15:0]                 end_row_i,
  input  logic [14:0]                 scroll_x_i,
  input  logic [15:0]                 scroll_row_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [shr_pkg::CIDXW-1:0]   cfg_index_i,
  input  logic [shr_pkg::CDATAW-1:0]  cfg_data_i,
  output logic                        valid_o,
  output logic signed [31:0]          rect_left_o,
  output logic signed [31:0]          rect_top_o,
  output logic signed [31:0]          rect_right_o,
  output logic signed [31:0]          rect_bottom_o,
  output logic                        last_rect_o
);
  import shr_pkg::*;

  cfg_t      cfg_q;
  cfg_t      cfg_d;
  item_t     item_q;
  logic      s0_vld_q, s0_vld_d;
  logic      s1_vld_q, s1_vld_d;
  logic      s0_adv, s1_adv;
  logic      accept;
  logic      buf_free;
  logic      load;
  geom_t     geom;
  rect_set_t set;
  rect_t     rect;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VIEW_LEFT:   cfg_d.view_left   = cfg_data_i;
        CFG_VIEW_WIDTH:  cfg_d.view_width  = cfg_data_i;
        CFG_VIEW_HEIGHT: cfg_d.view_height = cfg_data_i;
        CFG_CONTENT_TOP: cfg_d.content_top = cfg_data_i;
        CFG_CHAR_WIDTH:  cfg_d.char_width  = cfg_data_i[7:0];
        CFG_LINE_HEIGHT: cfg_d.line_height = cfg_data_i[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_left   <= '0;
      cfg_q.view_width  <= '0;
      cfg_q.view_height <= '0;
      cfg_q.content_top <= '0;
      cfg_q.char_width  <= 8'd8;
      cfg_q.line_height <= 8'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Each stage moves on when the one after it is empty or moving on too.
  assign s1_adv   = !s1_vld_q || buf_free;
  assign s0_adv   = !s0_vld_q || s1_adv;
  assign busy     = !s0_adv;
  assign accept   = start && !busy;
  assign load     = s1_vld_q && buf_free;
  assign s0_vld_d = accept || (s0_vld_q && !s1_adv);
  assign s1_vld_d = s1_adv ? s0_vld_q : s1_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= s0_vld_d;
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.start_col_px <= start_col_px_i;
      item_q.start_row    <= start_row_i;
      item_q.end_col_px   <= end_col_px_i;
      item_q.end_row      <= end_row_i;
      item_q.scroll_x     <= scroll_x_i;
      item_q.scroll_row   <= scroll_row_i;
    end
  end

  shr_geom u_geom (
    .clk_i  (clk_i),
    .en_i   (s1_adv && s0_vld_q),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .geom_o (geom)
  );

  shr_rects u_rects (
    .geom_i (geom),
    .cfg_i  (cfg_q),
    .set_o  (set)
  );

  shr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .set_i   (set),
    .free_o  (buf_free),
    .valid_o (valid_o),
    .rect_o  (rect),
    .last_o  (last_rect_o)
  );

  assign rect_left_o   = {{(OUTW-CW){rect.left[CW-1]}},   rect.left};
  assign rect_top_o    = {{(OUTW-CW){rect.top[CW-1]}},    rect.top};
  assign rect_right_o  = {{(OUTW-CW){rect.right[CW-1]}},  rect.right};
  assign rect_bottom_o = {{(OUTW-CW){rect.bottom[CW-1]}}, rect.bottom};

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !buf_free) |=> s1_vld_q)
    else $error("geometry stage dropped an item while the buffer was full");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (s0_vld_q && s1_vld_q))
    else $error("busy raised while a stage was empty");

  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s0_vld_q)
    else $error("accepted selection not held in the input stage");

endmodule
